### hw/rtl/tts_pkg.sv
// Shared types and constants of the touch rise-time scanner.
`timescale 1ns / 1ps

package tts_pkg;

   localparam int Slots       = 7;
   localparam int Channels    = 7;
   localparam int MaxSamples  = 32;
   localparam int CountWidth  = 6;
   localparam int SlotWidth   = 6;
   localparam int PinWidth    = 5;
   localparam int WordWidth   = 32;
   localparam int MapWidth    = Slots * SlotWidth;
   localparam int CsrIdxWidth = 1;

   localparam logic [MapWidth-1:0]   MapReset       = 42'h3AF3D04028B;
   localparam logic [CountWidth-1:0] ThresholdReset = '0;

   // register indexes of the configuration port
   localparam logic [CsrIdxWidth-1:0] CsrChannelMap = 1'b0;
   localparam logic [CsrIdxWidth-1:0] CsrThreshold  = 1'b1;

   typedef logic [CountWidth-1:0] count_type;
   typedef logic [SlotWidth-1:0]  slot_type;

   typedef struct packed {
      logic [WordWidth-1:0] port_word;
      logic                 port_sel;
      logic                 first_sample;
      logic                 last_sample;
      logic                 frame_end;
   } req_type;

   typedef struct packed {
      logic [Slots-1:0] pressed_bits;
      logic             changed;
      count_type        count_ch0;
      count_type        count_ch1;
      count_type        count_ch2;
      count_type        count_ch3;
      count_type        count_ch4;
      count_type        count_ch5;
      count_type        count_ch6;
   } rsp_type;

   // what every lane needs to know about the item being taken
   typedef struct packed {
      logic accept;
      logic port_sel;
      logic first_sample;
   } lane_ctrl_type;

endpackage

### hw/rtl/tts_lane.sv
// One channel lane: rise-time counter and seen flag for a single pad.
`timescale 1ns / 1ps

module tts_lane
   import tts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  lane_ctrl_type        ctrl,
   input  slot_type             slot,
   input  logic [WordWidth-1:0] port_word,
   output count_type            count_next
);

   count_type count_ff, count_in;
   logic      seen_ff, seen_in;

   logic      match;
   count_type count_base;
   logic      seen_base;

   assign match = ctrl.accept && (slot[SlotWidth-1] == ctrl.port_sel);

   always_comb begin
      count_base = ctrl.first_sample ? '0 : count_ff;
      seen_base  = ctrl.first_sample ? 1'b0 : seen_ff;
      count_in   = count_ff;
      seen_in    = seen_ff;
      if (match) begin
         count_in = count_base;
         seen_in  = seen_base;
         if (!seen_base) begin
            if (port_word[slot[PinWidth-1:0]]) begin
               seen_in = 1'b1;
            end else if (count_base < CountWidth'(MaxSamples)) begin
               count_in = count_base + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         seen_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         seen_ff  <= seen_in;
      end
   end

   assign count_next = count_in;

endmodule

### hw/rtl/tts_merge.sv
// Merge stage: builds the report from the lane counts and buffers it.
`timescale 1ns / 1ps

module tts_merge
   import tts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   report,
   input  count_type [Slots-1:0]  counts,
   input  count_type              threshold,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   output logic                   full
);

   logic [Slots-1:0] reported_ff, reported_in;
   logic [Slots-1:0] pressed;
   rsp_type          result;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   always_comb begin
      for (int c = 0; c < Slots; c++) begin
         pressed[c] = (c < Channels) && (counts[c] > threshold);
      end
   end

   always_comb begin
      result.pressed_bits = pressed;
      result.changed      = (pressed != reported_ff);
      result.count_ch0    = counts[0];
      result.count_ch1    = counts[1];
      result.count_ch2    = counts[2];
      result.count_ch3    = counts[3];
      result.count_ch4    = counts[4];
      result.count_ch5    = counts[5];
      result.count_ch6    = counts[6];
   end

   assign reported_in = report ? pressed : reported_ff;
   assign pop         = out_valid_ff && rsp_ready;

   // output register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (report) begin
            out_data_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (report) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reported_ff   <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         reported_ff   <= reported_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;
   assign full        = skid_valid_ff;

endmodule

### hw/rtl/touch_rise_time_scanner.sv
// Top level of the touch rise-time scanner: configuration, lanes and merge.
`timescale 1ns / 1ps

// Capacitive touch scanner by rise-time sensing. Each item is one GPIO port
// sample taken after the pads were discharged and released; every channel
// mapped to that port counts samples until its pin first reads high, holding
// at MaxSamples. An item with both last_sample and frame_end produces one
// report item (pressed bitmap, change flag, seven counts) on the rsp side,
// registered in the merge stage. While req_ready is high the block takes one
// item per clock: all channel lanes update in the same cycle, and the merge
// stage builds the report from the lanes' updated counts. req_ready drops
// only while two reports are held back by rsp_ready low, one in the output
// register and one in the skid entry; it rises again the cycle after rsp
// takes one. The configuration port writes channel_map (index 0) and
// press_threshold (index 1) at once, with no handshake.

module touch_rise_time_scanner
   import tts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_write_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [MapWidth-1:0]    csr_wdata
);

   logic [MapWidth-1:0] map_ff, map_in;
   count_type           thr_ff, thr_in;

   logic                  accept;
   logic                  report;
   logic                  full;
   lane_ctrl_type         ctrl;
   count_type [Slots-1:0] counts;

   // configuration registers: write straight through, drop unknown indexes
   always_comb begin
      map_in = map_ff;
      thr_in = thr_ff;
      if (csr_write_en) begin
         case (csr_index)
            CsrChannelMap: map_in = csr_wdata;
            CsrThreshold:  thr_in = csr_wdata[CountWidth-1:0];
            default: begin
               map_in = map_ff;
               thr_in = thr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= MapReset;
         thr_ff <= ThresholdReset;
      end else begin
         map_ff <= map_in;
         thr_ff <= thr_in;
      end
   end

   // hold off new items only while both report buffers are occupied
   assign req_ready = !full;
   assign accept    = req_valid && req_ready;
   assign report    = accept && req_payload.last_sample && req_payload.frame_end;

   assign ctrl.accept       = accept;
   assign ctrl.port_sel     = req_payload.port_sel;
   assign ctrl.first_sample = req_payload.first_sample;

   // one lane per active channel; unused slots read as zero
   for (genvar c = 0; c < Slots; c++) begin : g_lane
      if (c < Channels) begin : g_used
         tts_lane u_lane (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .slot       (map_ff[c*SlotWidth +: SlotWidth]),
            .port_word  (req_payload.port_word),
            .count_next (counts[c])
         );
      end else begin : g_unused
         assign counts[c] = '0;
      end
   end

   tts_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .report      (report),
      .counts      (counts),
      .threshold   (thr_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .full        (full)
   );

endmodule

### dv/tb_top.sv
// Self-checking testbench for the touch rise-time scanner.
`timescale 1ns / 1ps

// Drives port samples into the scanner over the req channel and checks
// every report on the rsp channel against a cycle-free prediction of the
// per-channel rise counts, the pressed bitmap and the change flag. Items
// are predicted at the edge where they are taken, so the expected reports
// queue up in the same order the block must emit them. Configuration is
// only rewritten with the block idle and every expected report drained.

module tb_top;
   import tts_pkg::*;

   localparam int CycleLimit   = 500000;
   localparam int SettleCycles = 4;
   localparam int RandomItems  = 1150;
   localparam int MaxShown     = 10;
   localparam int Settings     = 6;

   // ---------------------------------------------------------------- DUT pins
   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   req_type                req_payload  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_write_en = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index    = CsrChannelMap;
   logic [MapWidth-1:0]    csr_wdata    = '0;

   // ------------------------------------------------------- predicted state
   logic [MapWidth-1:0] map_copy       = MapReset;
   count_type           threshold_copy = ThresholdReset;
   count_type           rise_tally [Slots] = '{default: '0};
   logic [Slots-1:0]    rise_done      = '0;
   logic [Slots-1:0]    last_pressed   = '0;
   rsp_type             pending_reports [$];
   rsp_type             oldest_report;

   // ------------------------------------------------------ run bookkeeping
   int cycle_count   = 0;
   int sample_count  = 0;
   int sent_count    = 0;
   int report_count  = 0;
   int fail_count    = 0;
   int setting_count = 0;
   int full_cycles   = 0;

   // idling controls, written by the test sequence
   bit send_gaps = 1'b0;
   bit rsp_gaps  = 1'b0;
   int hold_len  = 0;
   int hold_seq  = 0;

   // receiver's own counters
   int hold_seen  = 0;
   int hold_left  = 0;
   int stall_left = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   touch_rise_time_scanner uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // ------------------------------------------------------------ prediction

   // Advance the rise counts for one taken sample and queue a report when
   // the sample closes a frame (last_sample together with frame_end).
   function automatic void predict_sample(req_type s);
      slot_type         slot;
      count_type        cnt [Slots];
      logic [Slots-1:0] pressed;
      rsp_type          rep;
      int               c;
      for (c = 0; c < Channels; c++) begin
         slot = map_copy[c*SlotWidth +: SlotWidth];
         // only channels wired to the sampled port take part
         if (slot[SlotWidth-1] == s.port_sel) begin
            // a run start clears first, then counts this very sample
            if (s.first_sample) begin
               rise_tally[c] = '0;
               rise_done[c]  = 1'b0;
            end
            if (!rise_done[c]) begin
               if (s.port_word[slot[PinWidth-1:0]])
                  rise_done[c] = 1'b1;
               else if (rise_tally[c] < MaxSamples)
                  rise_tally[c] = rise_tally[c] + 1'b1;
            end
         end
      end
      if (s.last_sample && s.frame_end) begin
         pressed = '0;
         for (c = 0; c < Slots; c++) begin
            cnt[c] = (c < Channels) ? rise_tally[c] : '0;
            if (c < Channels && cnt[c] > threshold_copy)
               pressed[c] = 1'b1;
         end
         rep.pressed_bits = pressed;
         rep.changed      = (pressed != last_pressed);
         rep.count_ch0    = cnt[0];
         rep.count_ch1    = cnt[1];
         rep.count_ch2    = cnt[2];
         rep.count_ch3    = cnt[3];
         rep.count_ch4    = cnt[4];
         rep.count_ch5    = cnt[5];
         rep.count_ch6    = cnt[6];
         last_pressed     = pressed;
         pending_reports.push_back(rep);
      end
   endfunction

   // Take note of every item at the edge where it is accepted; count the
   // cycles where the block turns an offered item away.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sample_count++;
         predict_sample(req_payload);
      end
      if (!reset && req_valid && !req_ready)
         full_cycles++;
   end

   // --------------------------------------------------------------- checking

   function automatic string report_text(rsp_type r);
      return $sformatf("pressed=%b changed=%b counts=%0d,%0d,%0d,%0d,%0d,%0d,%0d",
                       r.pressed_bits, r.changed, r.count_ch0, r.count_ch1,
                       r.count_ch2, r.count_ch3, r.count_ch4, r.count_ch5,
                       r.count_ch6);
   endfunction

   function automatic bit same_report(rsp_type a, rsp_type b);
      return (a.pressed_bits === b.pressed_bits) && (a.changed === b.changed) &&
             (a.count_ch0 === b.count_ch0) && (a.count_ch1 === b.count_ch1) &&
             (a.count_ch2 === b.count_ch2) && (a.count_ch3 === b.count_ch3) &&
             (a.count_ch4 === b.count_ch4) && (a.count_ch5 === b.count_ch5) &&
             (a.count_ch6 === b.count_ch6);
   endfunction

   // Report the first few problems in full; only count the rest.
   function automatic void note_failure(string what);
      fail_count++;
      if (fail_count <= MaxShown)
         $display("ERROR at cycle %0d: %s", cycle_count, what);
   endfunction

   // Match every report the block hands over against the oldest one queued.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            note_failure({"unexpected report ", report_text(rsp_payload)});
         end else begin
            oldest_report = pending_reports.pop_front();
            report_count++;
            if (!same_report(oldest_report, rsp_payload))
               note_failure({"report mismatch, expected ", report_text(oldest_report),
                             ", got ", report_text(rsp_payload)});
         end
      end
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles with %0d reports outstanding",
                  cycle_count, pending_reports.size());
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- idling

   // Mostly no gap, otherwise short, now and then long.
   function automatic int pick_gap(bit enabled);
      if (!enabled || $urandom_range(0, 99) < 55)
         return 0;
      if ($urandom_range(0, 99) < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Receiver: a requested hold-off takes priority over the random stalls.
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         stall_left = pick_gap(rsp_gaps);
         rsp_ready <= (stall_left == 0);
         if (stall_left > 0)
            stall_left--;
      end
   end

   // --------------------------------------------------------------- driving

   // Offer one item after a random gap and hold it until it is taken.
   // Valid stays high into the next item when there is no gap.
   task automatic send_sample(req_type item);
      int gap;
      gap = pick_gap(send_gaps);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // Drop valid, wait for every queued report, then let the pipe settle.
   task automatic drain_reports();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(logic [CsrIdxWidth-1:0] idx, logic [MapWidth-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == CsrChannelMap)
         map_copy = data;
      else
         threshold_copy = data[CountWidth-1:0];
   endtask

   function automatic logic [MapWidth-1:0] random_map();
      return {(MapWidth-32)'($urandom), $urandom};
   endfunction

   // Write both registers; junk rides above the threshold field.
   task automatic configure(logic [MapWidth-1:0] map, int threshold);
      logic [MapWidth-1:0] data;
      write_register(CsrChannelMap, map);
      data = random_map();
      data[CountWidth-1:0] = CountWidth'(threshold);
      write_register(CsrThreshold, data);
      setting_count++;
   endtask

   function automatic req_type make_sample(logic [31:0] word, logic port,
                                           logic first, logic last, logic fend);
      req_type s;
      s.port_word    = word;
      s.port_sel     = port;
      s.first_sample = first;
      s.last_sample  = last;
      s.frame_end    = fend;
      return s;
   endfunction

   // Force the mapped pins of this port: low before their rise sample, high
   // on it, left random afterwards since a risen channel stops looking.
   function automatic logic [31:0] shape_word(logic [31:0] word, logic port, int idx,
                                              int rise [Slots]);
      slot_type slot;
      int       c;
      for (c = 0; c < Channels; c++) begin
         slot = map_copy[c*SlotWidth +: SlotWidth];
         if (slot[SlotWidth-1] == port) begin
            if (idx < rise[c])
               word[slot[PinWidth-1:0]] = 1'b0;
            else if (idx == rise[c])
               word[slot[PinWidth-1:0]] = 1'b1;
         end
      end
      return word;
   endfunction

   // One frame: a run on one or both ports, each opened by first_sample and
   // closed by last_sample, with frame_end on the final run. Now and then
   // drop the opening mark, restart mid-run or put frame_end on its own.
   task automatic send_frame();
      req_type item;
      int      rise [Slots];
      int      runs;
      int      len;
      int      r;
      int      i;
      int      c;
      logic    port;
      runs = ($urandom_range(0, 3) == 0) ? 1 : 2;
      port = 1'($urandom_range(0, 1));
      for (r = 0; r < runs; r++) begin
         len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 40);
         for (c = 0; c < Slots; c++)
            rise[c] = $urandom_range(0, len + 2);
         for (i = 0; i < len; i++) begin
            item.port_word    = shape_word($urandom, port, i, rise);
            item.port_sel     = port;
            item.first_sample = (i == 0) ? ($urandom_range(0, 15) != 0)
                                         : ($urandom_range(0, 31) == 0);
            item.last_sample  = (i == len - 1);
            item.frame_end    = item.last_sample ? (r == runs - 1)
                                                 : ($urandom_range(0, 7) == 0);
            send_sample(item);
         end
         port = ~port;
      end
   endtask

   // A sample with every field random, flags included.
   task automatic send_noise();
      req_type item;
      {item.port_word, item.port_sel, item.first_sample,
       item.last_sample, item.frame_end} = {$urandom, 4'($urandom)};
      send_sample(item);
   endtask

   // ------------------------------------------------------------------ tests

   // Reset mapping: port 0 pins 11, 10, 0, 1 and port 1 pins 29, 28, 26.
   // Walk the run marks: last_sample alone, frame_end alone, counting outside
   // a run, a pin high on the opening sample, and repeated bitmaps.
   task automatic test_run_marks();
      send_gaps = 1'b1;
      rsp_gaps  = 1'b1;
      send_sample(make_sample(32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0));
      send_sample(make_sample(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0));
      send_sample(make_sample(32'h0000_0400, 1'b0, 1'b0, 1'b1, 1'b0));
      send_sample(make_sample(32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b1));
      send_sample(make_sample(32'h1000_0000, 1'b1, 1'b0, 1'b1, 1'b1));
      send_sample(make_sample(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1));
      send_sample(make_sample(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0));
      send_sample(make_sample(32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b1));
      send_sample(make_sample(32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b1));
      send_sample(make_sample(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1));
      send_sample(make_sample(32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b1));
      send_sample(make_sample(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1));
      send_sample(make_sample(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1));
   endtask

   // Pins that never rise: run each port past MaxSamples so counts hold.
   task automatic test_saturation();
      int   never [Slots];
      int   i;
      int   c;
      logic port;
      for (c = 0; c < Slots; c++)
         never[c] = MaxSamples + 16;
      for (c = 0; c < 2; c++) begin
         port = 1'(c);
         for (i = 0; i < MaxSamples + 8; i++)
            send_sample(make_sample(shape_word($urandom, port, i, never), port,
                                    i == 0, i == MaxSamples + 7, port));
      end
   endtask

   // Hold the receiver off for a long stretch while the sender keeps
   // offering frame-closing samples back to back, so the block backs up.
   task automatic test_backpressure();
      int i;
      send_gaps = 1'b0;
      hold_len  = 150;
      hold_seq++;
      for (i = 0; i < 24; i++)
         send_sample(make_sample($urandom, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'b1, 1'b1));
      drain_reports();
   endtask

   // Random frames under a series of settings, extremes included: every
   // channel on one pin of port 1 with nothing ever pressed, every channel on
   // pin 0 of port 0 just under saturation, and a zero threshold.
   task automatic test_random_settings();
      int setting;
      int target;
      for (setting = 0; setting < Settings; setting++) begin
         drain_reports();
         case (setting)
            0:       configure(random_map(), $urandom_range(1, 6));
            1:       configure('1, MaxSamples);
            2:       configure('0, MaxSamples - 1);
            3:       configure(random_map(), 0);
            4:       configure(MapReset, $urandom_range(0, MaxSamples));
            default: configure(random_map(), $urandom_range(0, MaxSamples));
         endcase
         target = sent_count + RandomItems / Settings;
         while (sent_count < target) begin
            // reshuffle idling now and then, so stretches run with none
            if ($urandom_range(0, 7) == 0) begin
               send_gaps = 1'($urandom_range(0, 1));
               rsp_gaps  = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 9) == 0)
               send_noise();
            else
               send_frame();
         end
      end
      drain_reports();
   endtask

   // ------------------------------------------------------------- sequence
   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_run_marks();
      test_saturation();
      test_backpressure();
      test_random_settings();
      // give a stray report time to show up
      repeat (SettleCycles) @(posedge clock);
      $display("Covered %0d samples and %0d reports under %0d register settings.",
               sample_count, report_count, setting_count);
      $display("Input was held off on %0d cycles; %0d problem(s) found.",
               full_cycles, fail_count);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
